// ===== hw/rtl/rle_sprite_blit_shade_unit_assert.svh =====
// Assertion macros shared by the sprite blitter RTL.
`ifndef RLE_SPRITE_BLIT_SHADE_UNIT_ASSERT_SVH
`define RLE_SPRITE_BLIT_SHADE_UNIT_ASSERT_SVH

// Clocked check that is switched off while the asynchronous reset is asserted.
`define RSBS_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that holds in every cycle, reset included.
`define RSBS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rsbs_pkg.sv =====
// Package with the shared types and constants of the run-length sprite blitter.
`default_nettype none

package rsbs_pkg;

	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths.
	localparam int YW      = 12;
	localparam int SKIP_W  = 12;
	localparam int ROWS_W  = 10;
	localparam int WORD_W  = 16;
	localparam int SHADE_W = 5;

	// Register reset values.
	localparam logic [12:0] SCREEN_WIDTH_RST = 13'd640;
	localparam logic [11:0] CLIP_BOTTOM_RST  = 12'd479;

	// Register index as seen on paddr[2].
	localparam logic REG_SCREEN_WIDTH = 1'b0;
	localparam logic REG_CLIP_BOTTOM  = 1'b1;

	// Input item kinds.
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_DATA   = 1'b1;

	// RGB555 channel masks.
	localparam logic [15:0] RED_MASK   = 16'h7C00;
	localparam logic [15:0] GREEN_MASK = 16'h03E0;
	localparam logic [15:0] BLUE_MASK  = 16'h001F;

	// Row parser phases.
	typedef enum logic [1:0] {
		PH_CLEAR,
		PH_LEN,
		PH_PIX,
		PH_NEXT
	} phase_t;

	// Vertical clipping result of a header.
	typedef struct packed {
		logic              none_visible;
		logic [YW-1:0]     first_y;
		logic [SKIP_W-1:0] skip_rows;
		logic [ROWS_W-1:0] draw_rows;
	} hdr_clip_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_sprite_blit_shade_unit.sv =====
// An accepted input transaction passes the input register and the parse stage into the result register.
// Throughput: one input transaction per cycle, set by the single parse stage after the
// input register; the input side stalls only while a result waits in a stalled output.
// A header or data word gives at most one result transaction (pixel write or sprite done).
// Reset (arst_n low, asynchronous) empties both stages, idles the parser and loads the
// screen width with 640 and the bottom clip line with 479.
`default_nettype none

`include "rle_sprite_blit_shade_unit_assert.svh"

module rle_sprite_blit_shade_unit import rsbs_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic signed [11:0] x_pos,
	input  logic signed [11:0] y_pos,
	input  logic [9:0]         top_offset,
	input  logic [9:0]         img_height,
	input  logic [4:0]         shade,
	input  logic [15:0]        data_word,
	// Output channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        pix_x,
	output logic [11:0]        pix_y,
	output logic [14:0]        color,
	output logic               sprite_done
);

	// The horizontal position must hold the sign of a header x and the saturation value.
	localparam int XW        = (COORD_BITS + 2 > 13) ? COORD_BITS + 2 : 13;
	localparam int SW        = XW + WORD_W + 1;
	localparam int WW        = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
	localparam int XSatInt   = (1 << (COORD_BITS + 1)) - 1;
	localparam int ScreenLim = 1 << COORD_BITS;
	localparam logic signed [SW-1:0] XSatWide = SW'(XSatInt);

	// Configuration registers.
	logic [12:0] screen_width_q;
	logic [11:0] clip_bottom_q;

	// Input stage.
	logic               vld_s1;
	logic               req_type_s1;
	logic signed [11:0] x_pos_s1;
	logic signed [11:0] y_pos_s1;
	logic [9:0]         top_offset_s1;
	logic [9:0]         img_height_s1;
	logic [4:0]         shade_s1;
	logic [15:0]        data_word_s1;

	// Parser state.
	logic                  active_q, active_d;
	phase_t                phase_q, phase_d;
	logic signed [XW-1:0]  cur_x_q, cur_x_d;
	logic signed [XW-1:0]  x_origin_q, x_origin_d;
	logic [YW-1:0]         cur_y_q, cur_y_d;
	logic [SKIP_W-1:0]     skip_q, skip_d;
	logic [ROWS_W-1:0]     rows_left_q, rows_left_d;
	logic [WORD_W-1:0]     run_left_q, run_left_d;
	logic [SHADE_W-1:0]    shade_q, shade_d;

	// Result register.
	logic        out_valid_q;
	logic [11:0] pix_x_q;
	logic [11:0] pix_y_q;
	logic [14:0] color_q;
	logic        done_q;

	// Stage decode.
	hdr_clip_t            hclip;
	logic                 s1_go, s1_fire;
	logic                 is_hdr, data_live, row_end, last_row, pix_vis;
	logic [WORD_W-1:0]    adv_n;
	logic signed [SW-1:0] adv_sum;
	logic signed [XW-1:0] adv_x;
	logic signed [XW-1:0] hdr_x;
	logic [WW-1:0]        sw_ext, w_eff;
	logic                 res_valid, res_done;
	logic [11:0]          res_x, res_y;
	logic [14:0]          res_color;

	// Each 5-bit channel loses the shade amount and stops at zero.
	function automatic logic [14:0] shade_pixel(input logic [15:0] p, input logic [4:0] s);
		logic [4:0] r, g, b;
		r = 5'((p & RED_MASK) >> 10);
		g = 5'((p & GREEN_MASK) >> 5);
		b = 5'(p & BLUE_MASK);
		r = (r > s) ? r - s : '0;
		g = (g > s) ? g - s : '0;
		b = (b > s) ? b - s : '0;
		return {r, g, b};
	endfunction

	//------------------------------------------------------------------
	// Configuration registers. Writes land in the access phase; reads are
	// decoded on the register index bit.
	//------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			clip_bottom_q  <= CLIP_BOTTOM_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_SCREEN_WIDTH) begin
				screen_width_q <= pwdata[12:0];
			end else begin
				clip_bottom_q <= pwdata[11:0];
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_WIDTH: prdata = 32'(screen_width_q);
			REG_CLIP_BOTTOM:  prdata = 32'(clip_bottom_q);
			default:          prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Input register. The stage moves on when it makes no result or the
	// result register is free or being emptied this cycle, so a stalled
	// output only holds up the input while a result is pending.
	//------------------------------------------------------------------
	assign s1_go    = !res_valid || !out_valid_q || !out_stall;
	assign s1_fire  = vld_s1 && s1_go;
	assign in_stall = vld_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_type_s1   <= req_type;
			x_pos_s1      <= x_pos;
			y_pos_s1      <= y_pos;
			top_offset_s1 <= top_offset;
			img_height_s1 <= img_height;
			shade_s1      <= shade;
			data_word_s1  <= data_word;
		end
	end

	//------------------------------------------------------------------
	// Header clipping and the shared x adder. Only one phase advances x in
	// a given item, so a single saturating adder serves clear runs, skip
	// runs and the step after each pixel.
	//------------------------------------------------------------------
	rsbs_hdr_clip #(
		.COORD_BITS (COORD_BITS)
	) u_hdr_clip (
		.y_pos       (y_pos_s1),
		.top_offset  (top_offset_s1),
		.img_height  (img_height_s1),
		.clip_bottom (clip_bottom_q),
		.clip        (hclip)
	);

	assign hdr_x   = {{(XW-12){x_pos_s1[11]}}, x_pos_s1};
	assign adv_n   = (phase_q == PH_PIX) ? WORD_W'(1) : data_word_s1;
	assign adv_sum = {{(SW-XW){cur_x_q[XW-1]}}, cur_x_q} + {{(SW-WORD_W){1'b0}}, adv_n};
	assign adv_x   = (adv_sum > XSatWide) ? XW'(XSatInt) : adv_sum[XW-1:0];

	// Visible width is the register limited to the coordinate range.
	assign sw_ext = WW'(screen_width_q);
	assign w_eff  = (sw_ext > WW'(ScreenLim)) ? WW'(ScreenLim) : sw_ext;

	// Shared decode of the item in the stage.
	assign is_hdr    = (req_type_s1 == REQ_HEADER);
	assign data_live = (req_type_s1 == REQ_DATA) && active_q;
	assign row_end   = data_live && (data_word_s1 == '0)
	                   && ((phase_q == PH_LEN) || (phase_q == PH_NEXT));
	assign last_row  = (skip_q == '0) && (rows_left_q <= ROWS_W'(1));
	assign pix_vis   = data_live && (phase_q == PH_PIX) && (skip_q == '0)
	                   && !cur_x_q[XW-1] && ($unsigned(cur_x_q) < XW'(w_eff));

	//------------------------------------------------------------------
	// Next state of the row parser.
	//------------------------------------------------------------------
	always_comb begin
		active_d    = active_q;
		phase_d     = phase_q;
		cur_x_d     = cur_x_q;
		x_origin_d  = x_origin_q;
		cur_y_d     = cur_y_q;
		skip_d      = skip_q;
		rows_left_d = rows_left_q;
		run_left_d  = run_left_q;
		shade_d     = shade_q;
		if (is_hdr) begin
			// A new header always restarts, dropping any sprite in flight.
			x_origin_d = hdr_x;
			cur_x_d    = hdr_x;
			cur_y_d    = hclip.first_y;
			shade_d    = shade_s1;
			phase_d    = PH_CLEAR;
			run_left_d = '0;
			if (hclip.none_visible) begin
				active_d    = 1'b0;
				skip_d      = '0;
				rows_left_d = '0;
			end else begin
				active_d    = 1'b1;
				skip_d      = hclip.skip_rows;
				rows_left_d = hclip.draw_rows;
			end
		end else if (data_live) begin
			if (row_end) begin
				phase_d = PH_CLEAR;
				cur_x_d = x_origin_q;
				if (skip_q != '0) begin
					skip_d = skip_q - SKIP_W'(1);
				end else begin
					cur_y_d     = cur_y_q + YW'(1);
					rows_left_d = rows_left_q - ROWS_W'(1);
					if (last_row) begin
						active_d = 1'b0;
					end
				end
			end else begin
				unique case (phase_q)
					PH_CLEAR: begin
						cur_x_d = adv_x;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						run_left_d = data_word_s1;
						phase_d    = PH_PIX;
					end
					PH_PIX: begin
						cur_x_d    = adv_x;
						run_left_d = run_left_q - WORD_W'(1);
						if (run_left_q == WORD_W'(1)) begin
							phase_d = PH_NEXT;
						end
					end
					PH_NEXT: begin
						cur_x_d = adv_x;
						phase_d = PH_LEN;
					end
					default: begin
						phase_d = PH_CLEAR;
					end
				endcase
			end
		end
	end

	//------------------------------------------------------------------
	// Result of the item: a visible pixel, or the done marker when a header
	// has nothing to draw or the last drawn row ends.
	//------------------------------------------------------------------
	always_comb begin
		res_valid = 1'b0;
		res_done  = 1'b0;
		res_x     = '0;
		res_y     = '0;
		res_color = '0;
		if (vld_s1) begin
			if (is_hdr) begin
				res_valid = hclip.none_visible;
				res_done  = hclip.none_visible;
			end else if (row_end && last_row) begin
				res_valid = 1'b1;
				res_done  = 1'b1;
			end else if (pix_vis) begin
				res_valid = 1'b1;
				res_x     = cur_x_q[11:0];
				res_y     = cur_y_q;
				res_color = shade_pixel(data_word_s1, shade_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= PH_CLEAR;
			cur_x_q     <= '0;
			x_origin_q  <= '0;
			cur_y_q     <= '0;
			skip_q      <= '0;
			rows_left_q <= '0;
			run_left_q  <= '0;
			shade_q     <= '0;
		end else if (s1_fire) begin
			active_q    <= active_d;
			phase_q     <= phase_d;
			cur_x_q     <= cur_x_d;
			x_origin_q  <= x_origin_d;
			cur_y_q     <= cur_y_d;
			skip_q      <= skip_d;
			rows_left_q <= rows_left_d;
			run_left_q  <= run_left_d;
			shade_q     <= shade_d;
		end
	end

	//------------------------------------------------------------------
	// Result register. It refills in the same cycle that a result leaves.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			pix_x_q <= res_x;
			pix_y_q <= res_y;
			color_q <= res_color;
			done_q  <= res_done;
		end
	end

	assign out_valid   = out_valid_q;
	assign pix_x       = pix_x_q;
	assign pix_y       = pix_y_q;
	assign color       = color_q;
	assign sprite_done = done_q;

	// A running sprite always has a drawn row still to finish.
	`RSBS_ASSERT_RST(a_active_rows, clk, arst_n, active_q |-> (rows_left_q != '0), "active sprite with no rows left")
	// A pixel phase is entered only with a nonzero color run.
	`RSBS_ASSERT_RST(a_pix_run, clk, arst_n, (active_q && (phase_q == PH_PIX)) |-> (run_left_q != '0), "pixel phase with empty run")
	// The input is held back only by a pending result that the output stalls.
	`RSBS_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (vld_s1 && out_valid_q && out_stall), "input stall without a blocked result")
	// A done marker carries no pixel.
	`RSBS_ASSERT_RST(a_done_clean, clk, arst_n, (out_valid_q && done_q) |-> ((pix_x_q == '0) && (pix_y_q == '0) && (color_q == '0)), "done result carries pixel data")

endmodule

`default_nettype wire

// ===== hw/rtl/rsbs_hdr_clip.sv =====
// Vertical clipping of a sprite header against screen row 0 and the bottom clip line.
`default_nettype none

module rsbs_hdr_clip import rsbs_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic signed [11:0] y_pos,
	input  logic        [9:0]  top_offset,
	input  logic        [9:0]  img_height,
	input  logic        [11:0] clip_bottom,
	output hdr_clip_t          clip
);

	localparam int ClipLim = (COORD_BITS >= 12) ? 4096 : (1 << COORD_BITS);

	logic        [12:0] cb;
	logic signed [13:0] y0, h0, y1, h1, h2, skip, cb_s;

	always_comb begin
		y0 = $signed({{2{y_pos[11]}}, y_pos}) + $signed({4'b0, top_offset});
		h0 = $signed({4'b0, img_height});
		// Rows above the screen are parsed but skipped.
		if (y0[13]) begin
			skip = -y0;
			h1   = h0 + y0;
			y1   = '0;
		end else begin
			skip = '0;
			h1   = h0;
			y1   = y0;
		end
		cb   = ({1'b0, clip_bottom} > 13'(ClipLim)) ? 13'(ClipLim) : {1'b0, clip_bottom};
		cb_s = $signed({1'b0, cb});
		if (y1 + h1 > cb_s) begin
			h2 = cb_s - y1;
		end else begin
			h2 = h1;
		end
		clip.none_visible = h2[13] || (h2 == '0);
		clip.first_y      = y1[YW-1:0];
		clip.skip_rows    = skip[SKIP_W-1:0];
		clip.draw_rows    = h2[ROWS_W-1:0];
	end

endmodule

`default_nettype wire

// ===== verif/tb_rle_sprite_blit_shade_unit.sv =====
// Self-checking testbench that streams run-length sprites through the blitter and checks each pixel write.
`timescale 1ns / 1ps

module tb_rle_sprite_blit_shade_unit import rsbs_pkg::*; ();

	// The block is built with its default coordinate width, so the clip limits and the
	// saturation point of the column counter follow from that.
	localparam int COORD_LIMIT = 1 << COORD_BITS_DEF;
	localparam int X_SAT       = (1 << (COORD_BITS_DEF + 1)) - 1;

	// One input transaction as the sender offers it.
	typedef struct {
		logic               req_type;
		logic signed [11:0] x_pos;
		logic signed [11:0] y_pos;
		logic [9:0]         top_offset;
		logic [9:0]         img_height;
		logic [4:0]         shade;
		logic [15:0]        data_word;
	} stream_item_t;

	// One output transaction: a pixel write or the end-of-sprite marker.
	typedef struct {
		logic [11:0] pix_x;
		logic [11:0] pix_y;
		logic [14:0] color;
		logic        sprite_done;
	} pix_write_t;

	typedef enum {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_t;

	// The scoreboard keeps its own copy of the sprite decoder. Every accepted input
	// transaction is run through it, and the pixel writes it produces wait in
	// pending_writes until the block delivers them in order.
	class blit_scoreboard;
		int unsigned  screen_width;
		int unsigned  clip_bottom;
		bit           active;
		phase_t       phase;
		int           cur_x;
		int           cur_y;
		int           rows_to_skip;
		int           rows_left;
		int           x_origin;
		logic [15:0]  run_left;
		logic [4:0]   shade_amt;
		pix_write_t   pending_writes[$];
		int           errors;

		function new();
			screen_width = SCREEN_WIDTH_RST;
			clip_bottom  = CLIP_BOTTOM_RST;
			active       = 1'b0;
			phase        = PH_CLEAR;
			cur_x        = 0;
			cur_y        = 0;
			rows_to_skip = 0;
			rows_left    = 0;
			x_origin     = 0;
			run_left     = '0;
			shade_amt    = '0;
			errors       = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endtask

		function int coord_cap(int unsigned v);
			return (v > COORD_LIMIT) ? COORD_LIMIT : int'(v);
		endfunction

		function void expect_write(logic [11:0] x, logic [11:0] y, logic [14:0] c, logic d);
			pix_write_t w;
			w.pix_x       = x;
			w.pix_y       = y;
			w.color       = c;
			w.sprite_done = d;
			pending_writes.push_back(w);
		endfunction

		function void step_x(int unsigned n);
			longint nx;
			nx    = longint'(cur_x) + longint'(n);
			cur_x = (nx > X_SAT) ? X_SAT : int'(nx);
		endfunction

		function logic [14:0] dim_pixel(logic [15:0] p, logic [4:0] s);
			logic [4:0] r, g, b;
			r = 5'((p & RED_MASK) >> 10);
			g = 5'((p & GREEN_MASK) >> 5);
			b = 5'(p & BLUE_MASK);
			r = (r > s) ? r - s : 5'd0;
			g = (g > s) ? g - s : 5'd0;
			b = (b > s) ? b - s : 5'd0;
			return {r, g, b};
		endfunction

		// A zero word closes the row. Skipped rows above the screen only count down;
		// a drawn row moves down one line, and the last one ends the sprite.
		function void close_row();
			phase = PH_CLEAR;
			cur_x = x_origin;
			if (rows_to_skip > 0) begin
				rows_to_skip--;
				return;
			end
			cur_y++;
			rows_left--;
			if (rows_left <= 0) begin
				active = 1'b0;
				expect_write('0, '0, '0, 1'b1);
			end
		endfunction

		function void take_stream_item(stream_item_t it);
			int y, h, cb, skip, w;
			if (it.req_type == REQ_HEADER) begin
				y    = it.y_pos;
				y    = y + int'(it.top_offset);
				h    = int'(it.img_height);
				cb   = coord_cap(clip_bottom);
				skip = 0;
				if (y < 0) begin
					skip = -y;
					h    = h + y;
					y    = 0;
				end
				if (y + h > cb) h = cb - y;
				x_origin  = it.x_pos;
				cur_x     = x_origin;
				cur_y     = y;
				shade_amt = it.shade;
				phase     = PH_CLEAR;
				run_left  = '0;
				if (h <= 0) begin
					active       = 1'b0;
					rows_to_skip = 0;
					rows_left    = 0;
					expect_write('0, '0, '0, 1'b1);
				end else begin
					active       = 1'b1;
					rows_to_skip = skip;
					rows_left    = h;
				end
				return;
			end
			if (!active) return;
			case (phase)
				PH_CLEAR: begin
					step_x(it.data_word);
					phase = PH_LEN;
				end
				PH_LEN: begin
					if (it.data_word == 16'h0000) begin
						close_row();
					end else begin
						run_left = it.data_word;
						phase    = PH_PIX;
					end
				end
				PH_PIX: begin
					w = coord_cap(screen_width);
					if (rows_to_skip == 0 && cur_x >= 0 && cur_x < w) begin
						expect_write(cur_x[11:0], cur_y[11:0], dim_pixel(it.data_word, shade_amt),
							1'b0);
					end
					step_x(1);
					run_left--;
					if (run_left == 16'h0000) phase = PH_NEXT;
				end
				default: begin
					if (it.data_word == 16'h0000) begin
						close_row();
					end else begin
						step_x(it.data_word);
						phase = PH_LEN;
					end
				end
			endcase
		endfunction

		task check_pixel_write(pix_write_t got);
			pix_write_t want;
			if (pending_writes.size() == 0) begin
				report($sformatf("unexpected write x=%0d y=%0d color=%h done=%0b",
					got.pix_x, got.pix_y, got.color, got.sprite_done));
				return;
			end
			want = pending_writes.pop_front();
			if (got.sprite_done !== want.sprite_done)
				report($sformatf("sprite_done %0b, want %0b", got.sprite_done, want.sprite_done));
			if (got.pix_x !== want.pix_x)
				report($sformatf("pix_x %0d, want %0d", got.pix_x, want.pix_x));
			if (got.pix_y !== want.pix_y)
				report($sformatf("pix_y %0d, want %0d", got.pix_y, want.pix_y));
			if (got.color !== want.color)
				report($sformatf("color %h, want %h", got.color, want.color));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               req_type;
	logic signed [11:0] x_pos;
	logic signed [11:0] y_pos;
	logic [9:0]         top_offset;
	logic [9:0]         img_height;
	logic [4:0]         shade;
	logic [15:0]        data_word;
	logic               out_valid;
	logic               out_stall;
	logic [11:0]        pix_x;
	logic [11:0]        pix_y;
	logic [14:0]        color;
	logic               sprite_done;

	blit_scoreboard sb = new();

	// Stream words waiting to be offered, and the knobs that shape both sides' idling.
	stream_item_t tx_q[$];
	int           tx_gap_max   = 0;
	int           tx_burst_max = 1;
	rx_mode_t     rx_mode      = RX_FREE;
	bit           hold_request = 1'b0;

	rle_sprite_blit_shade_unit u_top (.*);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Safety net: a hung handshake or a lost result ends the run here.
	initial begin
		#20_000_000;
		$display("tb_rle_sprite_blit_shade_unit: FAIL");
		$finish;
	end

	// Every output transaction goes to the scoreboard the moment it is taken. Sampling
	// happens at the rising edge, before the block's own updates of that edge land.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_pixel_write(pix_write_t'{pix_x, pix_y, color, sprite_done});
		end
	end

	// The receiver. It normally follows rx_mode, but a hold request makes it refuse
	// results for a long stretch that it counts itself, so that the block backs up
	// into its input while the sender keeps offering words. Only one assignment to
	// out_stall happens per falling edge.
	initial begin
		int  hold_count;
		int  rx_run;
		bit  rx_busy;
		hold_count = 0;
		rx_run     = 0;
		rx_busy    = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_count   = 400;
			end
			if (hold_count > 0) begin
				hold_count--;
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					RX_FREE:   out_stall <= 1'b0;
					RX_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
					default: begin
						if (rx_run == 0) begin
							rx_busy = !rx_busy;
							rx_run  = rx_busy ? $urandom_range(1, 6) : $urandom_range(1, 10);
						end
						rx_run--;
						out_stall <= rx_busy;
					end
				endcase
			end
		end
	end

	function automatic stream_item_t make_hdr(int x, int y, int top, int h, int s);
		stream_item_t it;
		it.req_type   = REQ_HEADER;
		it.x_pos      = x[11:0];
		it.y_pos      = y[11:0];
		it.top_offset = top[9:0];
		it.img_height = h[9:0];
		it.shade      = s[4:0];
		it.data_word  = 16'($urandom);
		return it;
	endfunction

	// Header fields of a data transaction are don't-care, so they carry random bits.
	function automatic stream_item_t make_word(logic [15:0] w);
		stream_item_t it;
		it.req_type   = REQ_DATA;
		it.x_pos      = 12'($urandom);
		it.y_pos      = 12'($urandom);
		it.top_offset = 10'($urandom);
		it.img_height = 10'($urandom);
		it.shade      = 5'($urandom);
		it.data_word  = w;
		return it;
	endfunction

	function automatic stream_item_t make_noise();
		stream_item_t it;
		it           = make_word(16'($urandom));
		it.req_type  = 1'($urandom);
		return it;
	endfunction

	// Clear runs are mostly short so that pixels land on screen; now and then a huge
	// one drives the column counter into saturation.
	function automatic logic [15:0] pick_clear();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16) return 16'($urandom_range(0, 6));
		if (r < 19) return 16'($urandom_range(0, 64));
		return 16'($urandom);
	endfunction

	// A skip between color runs must be nonzero, or it would close the row.
	function automatic logic [15:0] pick_skip();
		if ($urandom_range(0, 7) != 0) return 16'($urandom_range(1, 5));
		return 16'($urandom_range(1, 65535));
	endfunction

	// One encoded row. It ends either with a zero in place of the next skip, or with a
	// skip followed by a zero color-run length.
	task automatic push_row();
		int pairs, len;
		pairs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		tx_q.push_back(make_word(pick_clear()));
		for (int k = 0; k < pairs; k++) begin
			if (k > 0) tx_q.push_back(make_word(pick_skip()));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			tx_q.push_back(make_word(16'(len)));
			repeat (len) tx_q.push_back(make_word(16'($urandom)));
		end
		if (pairs > 0 && $urandom_range(0, 4) == 0) tx_q.push_back(make_word(pick_skip()));
		tx_q.push_back(make_word(16'h0000));
	endtask

	// A well-formed sprite placed mostly where it meets the current clip window. Some
	// are left unfinished so that the next header has to abandon them, and some have
	// stray words after their end.
	task automatic push_sprite();
		int w, cb, top, yv, xv, h, rows;
		w   = (sb.screen_width > COORD_LIMIT) ? COORD_LIMIT : int'(sb.screen_width);
		cb  = int'(sb.clip_bottom);
		top = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: yv = int'($urandom_range(0, (cb > 0) ? cb - 1 : 0)) - top;
			6, 7:             yv = -int'($urandom_range(1, 6)) - top;
			default:          yv = int'($urandom_range(0, 4095)) - 2048;
		endcase
		if (yv > 2047) yv = 2047;
		if (yv < -2048) yv = -2048;
		if ($urandom_range(0, 9) < 7) xv = int'($urandom_range(0, w + 8)) - 8;
		else xv = int'($urandom_range(0, 4095)) - 2048;
		if (xv > 2047) xv = 2047;
		h    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 5);
		rows = (h <= 5) ? h : $urandom_range(0, 4);
		if (rows > 0 && $urandom_range(0, 9) == 0) rows--;
		tx_q.push_back(make_hdr(xv, yv, top, h, $urandom_range(0, 31)));
		repeat (rows) push_row();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 2)) tx_q.push_back(make_word(16'($urandom)));
		end
	endtask

	// A header followed by words with no row structure at all.
	task automatic push_broken();
		tx_q.push_back(make_hdr($urandom_range(0, 48) - 8, $urandom_range(0, 20), 0,
			$urandom_range(1, 8), $urandom_range(0, 31)));
		repeat ($urandom_range(1, 20)) begin
			case ($urandom_range(0, 3))
				0:       tx_q.push_back(make_word(16'h0000));
				1:       tx_q.push_back(make_word(16'($urandom)));
				default: tx_q.push_back(make_word(16'($urandom_range(0, 8))));
			endcase
		end
	endtask

	// Fill the stream for one random phase: mostly sprites, some broken ones, and a
	// little noise that only counts as padding.
	task automatic build_phase(int target);
		int counted, start_size, pick;
		counted = 0;
		while (counted < target) begin
			start_size = tx_q.size();
			pick       = $urandom_range(0, 19);
			if (pick < 2) begin
				repeat ($urandom_range(1, 4)) tx_q.push_back(make_noise());
			end else begin
				if (pick == 2) push_broken();
				else push_sprite();
				counted += tx_q.size() - start_size;
			end
		end
	endtask

	// Offer one input transaction and hold it until the block takes it. The payload
	// changes only at a falling edge, and acceptance is judged at the rising edge.
	task automatic send_item(stream_item_t it);
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= it.req_type;
		x_pos      <= it.x_pos;
		y_pos      <= it.y_pos;
		top_offset <= it.top_offset;
		img_height <= it.img_height;
		shade      <= it.shade;
		data_word  <= it.data_word;
		do @(posedge clk); while (in_stall);
		sb.take_stream_item(it);
	endtask

	task automatic idle_input(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Send the whole queue in bursts of random length with random gaps between them.
	// Valid stays high from one transaction to the next inside a burst.
	task automatic flush_stream();
		int burst_left;
		burst_left = 0;
		while (tx_q.size() != 0) begin
			if (burst_left == 0) begin
				if (tx_gap_max > 0) idle_input($urandom_range(0, tx_gap_max));
				burst_left = $urandom_range(1, tx_burst_max);
			end
			send_item(tx_q.pop_front());
			burst_left--;
		end
		idle_input(1);
	endtask

	// Wait until every predicted result has come, then give the pipeline more time, since
	// trailing words that cause no result may still be in flight.
	task automatic wait_results();
		while (sb.pending_writes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_SCREEN_WIDTH) sb.screen_width = value[12:0];
		else sb.clip_bottom = value[11:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// The bits above each register's width carry junk; the block must ignore them.
	task automatic set_clip(int unsigned w, int unsigned cb);
		cfg_write({REG_SCREEN_WIDTH, 2'b00}, {19'($urandom), 13'(w)});
		cfg_write({REG_CLIP_BOTTOM, 2'b00}, {20'($urandom), 12'(cb)});
	endtask

	int unsigned width_set[8] = '{640, 1, 4096, 8191, 0, 64, 300, 2047};
	int unsigned clip_set[8]  = '{479, 1, 4095, 4095, 300, 32, 0, 1500};

	initial begin
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		req_type   = REQ_HEADER;
		x_pos      = '0;
		y_pos      = '0;
		top_offset = '0;
		img_height = '0;
		shade      = '0;
		data_word  = '0;
		arst_n     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, under the reset values of the registers (width 640, clip 479).
		// A data word while idle is ignored.
		tx_q.push_back(make_word(16'h1234));
		// A header of zero height gives the done marker at once.
		tx_q.push_back(make_hdr(100, 100, 0, 0, 0));
		// Extreme headers that clip away entirely, above and below the screen.
		tx_q.push_back(make_hdr(-2048, -2048, 1023, 1023, 31));
		tx_q.push_back(make_hdr(2047, 2047, 1023, 1023, 0));
		// Sprite starting one row above and one column left of the screen: the first
		// row is parsed but skipped, the second drops its left pixel and draws one.
		tx_q.push_back(make_hdr(-1, -1, 0, 2, 0));
		tx_q.push_back(make_word(16'h0000));
		tx_q.push_back(make_word(16'h0001));
		tx_q.push_back(make_word(16'h7FFF));
		tx_q.push_back(make_word(16'h0000));
		tx_q.push_back(make_word(16'h0000));
		tx_q.push_back(make_word(16'h0002));
		tx_q.push_back(make_word(16'hFFFF));
		tx_q.push_back(make_word(16'h7FFF));
		tx_q.push_back(make_word(16'h0000));
		// Full shade, and a clear run that saturates the column counter, then a new
		// header while this sprite is still running.
		tx_q.push_back(make_hdr(0, 0, 0, 3, 31));
		tx_q.push_back(make_word(16'hFFFF));
		tx_q.push_back(make_word(16'h0001));
		tx_q.push_back(make_word(16'h7FFF));
		tx_q.push_back(make_word(16'h0000));
		// Sprite cut at the bottom clip line down to one row, whose run crosses the
		// right edge. The row ends with a skip and a zero run length.
		tx_q.push_back(make_hdr(636, 478, 0, 4, 3));
		tx_q.push_back(make_word(16'h0002));
		tx_q.push_back(make_word(16'h0003));
		tx_q.push_back(make_word(16'h8421));
		tx_q.push_back(make_word(16'h7C1F));
		tx_q.push_back(make_word(16'h03E0));
		tx_q.push_back(make_word(16'h0001));
		tx_q.push_back(make_word(16'h0000));
		// Data after the sprite has ended is ignored.
		tx_q.push_back(make_word(16'h5555));
		tx_gap_max   = 0;
		tx_burst_max = 1;
		rx_mode      = RX_FREE;
		flush_stream();
		wait_results();

		// Back-pressure: the receiver refuses results for a long stretch while a row of
		// sixty visible pixels is offered back to back, so the block has to stall its
		// input. The sender then waits for every result before going on.
		set_clip(640, 479);
		tx_q.push_back(make_hdr(0, 5, 0, 1, $urandom_range(0, 31)));
		tx_q.push_back(make_word(16'h0000));
		tx_q.push_back(make_word(16'd60));
		repeat (60) tx_q.push_back(make_word(16'($urandom)));
		tx_q.push_back(make_word(16'h0000));
		hold_request = 1'b1;
		tx_gap_max   = 0;
		tx_burst_max = 1;
		flush_stream();
		wait_results();

		// Random phases, one per clip setting. The first runs with no idling on either
		// side; the rest pick their own idling.
		for (int p = 0; p < 8; p++) begin
			set_clip(width_set[p], clip_set[p]);
			if (p == 0) begin
				rx_mode      = RX_FREE;
				tx_gap_max   = 0;
				tx_burst_max = 1;
			end else begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0:       tx_gap_max = 0;
					1:       tx_gap_max = 2;
					default: tx_gap_max = 8;
				endcase
				tx_burst_max = $urandom_range(1, 20);
			end
			build_phase(182);
			flush_stream();
			wait_results();
		end

		if (sb.errors == 0) begin
			$display("tb_rle_sprite_blit_shade_unit: PASS");
		end else begin
			$display("tb_rle_sprite_blit_shade_unit: FAIL");
		end
		$finish;
	end

endmodule
